FILE: rtl/spct_pkg.sv
// Shared types and constants for the shortest path unit.
package spct_pkg;

   localparam int MaxVertices = 64;
   localparam int MaxEdges    = 256;

   localparam logic signed [31:0] S32Max = 32'sh7fffffff;
   localparam logic signed [31:0] S32Min = 32'sh80000000;

   // Operation codes of an input beat.
   localparam logic [1:0] OpAppend = 2'd0;
   localparam logic [1:0] OpRun    = 2'd1;
   localparam logic [1:0] OpClear  = 2'd2;

   // Configuration register indexes.
   localparam logic [0:0] CsrVertexCount = 1'b0;
   localparam logic [0:0] CsrStartVertex = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_CALC,
      ST_HEAD,
      ST_WRITE,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic append;
      logic clear;
      logic init_vtx;
      logic edge_rd;
      logic vtx_rd;
      logic head_rd;
      logic relax_wr;
      logic emit_rd;
      logic emit;
   } cmd_type;

   // Saturating signed 32-bit add of a path value and a 16-bit weight.
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [15:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {{17{b[15]}}, b};
      if (s > 33'sh07fffffff) return S32Max;
      if (s < -33'sh080000000) return S32Min;
      return s[31:0];
   endfunction

endpackage

FILE: rtl/spct_ram.sv
// Generic single-port RAM with registered read.
module spct_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // Read data is registered; a read of the address being written returns the old entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

FILE: rtl/spct_datapath.sv
// Edge store, vertex tables and relaxation arithmetic.
module spct_datapath #(
   parameter int MaxVertices = spct_pkg::MaxVertices,
   parameter int MaxEdges    = spct_pkg::MaxEdges,
   localparam int VW = $clog2(MaxVertices),
   localparam int EW = $clog2(MaxEdges)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spct_pkg::cmd_type     cmd,
   input  logic [EW-1:0]         edge_idx,
   input  logic [VW-1:0]         vtx_idx,
   input  logic [VW-1:0]         from_vertex,
   input  logic [VW-1:0]         to_vertex,
   input  logic signed [15:0]    distance_weight,
   input  logic signed [15:0]    cost_weight,
   input  logic [VW:0]           vcount,
   input  logic [VW-1:0]         start_vertex,
   output logic [EW:0]           edge_total,
   output logic                  rsp_valid,
   output logic [VW-1:0]         rsp_vertex,
   output logic                  rsp_reachable,
   output logic signed [31:0]    rsp_path_distance,
   output logic signed [31:0]    rsp_path_cost,
   output logic                  rsp_has_predecessor,
   output logic [VW-1:0]         rsp_predecessor,
   output logic                  rsp_last
);
   localparam int EdgeW = 2 * VW + 32;
   localparam int VtxW  = 2 + 64 + VW;

   logic [EW:0]        total_ff, total_in;
   logic               ewr;
   logic [EW-1:0]      eaddr;
   logic [EdgeW-1:0]   ewdata, erdata;
   logic               vwr;
   logic [VW-1:0]      vaddr;
   logic [VtxW-1:0]    vwdata, vrdata;
   logic [VW-1:0]      e_tail, e_head;
   logic signed [15:0] e_dw, e_cw;
   logic               v_reach, v_pv;
   logic signed [31:0] v_d, v_c;
   logic [VW-1:0]      v_p;
   logic [VW-1:0]      tail_ff, head_ff;
   logic signed [15:0] e_dw_ff, e_cw_ff;
   logic signed [31:0] nd_ff, nc_ff;
   logic               go_ff;
   logic               upd_in;
   logic [VW-1:0]      emit_v_ff;

   assign edge_total = total_ff;

   // Edge count register.
   always_comb begin
      total_in = total_ff;
      if (cmd.clear) begin
         total_in = '0;
      end else if (cmd.append && total_ff < (EW + 1)'(MaxEdges)) begin
         total_in = total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign ewr    = cmd.append && total_ff < (EW + 1)'(MaxEdges);
   assign eaddr  = ewr ? total_ff[EW-1:0] : edge_idx;
   assign ewdata = {from_vertex, to_vertex, distance_weight, cost_weight};

   spct_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edges (
      .clock(clock), .wr_en(ewr), .addr(eaddr), .wr_data(ewdata), .rd_data(erdata)
   );

   // Vertex entry: reached, pred valid, distance, cost, predecessor.
   assign {e_tail, e_head, e_dw, e_cw} = erdata;
   assign {v_reach, v_pv, v_d, v_c, v_p} = vrdata;

   // Address: init sweep and emit read, tail read, head read and write.
   always_comb begin
      vaddr = vtx_idx;
      if (cmd.vtx_rd) vaddr = e_tail;
      if (cmd.head_rd || cmd.relax_wr) vaddr = head_ff;
   end

   // Write data: the init entry, or the relaxation decision on the head entry read in the previous cycle.
   always_comb begin
      upd_in = 1'b0;
      vwdata = {1'b0, 1'b0, spct_pkg::S32Max, spct_pkg::S32Max, {VW{1'b0}}};
      if (cmd.init_vtx) begin
         if (vtx_idx == start_vertex && {1'b0, start_vertex} < vcount) begin
            vwdata = {1'b1, 1'b0, 32'sd0, 32'sd0, {VW{1'b0}}};
         end
      end else if (!v_reach || nd_ff < v_d) begin
         upd_in = go_ff;
         vwdata = {1'b1, 1'b1, nd_ff, nc_ff, tail_ff};
      end else begin
         upd_in = go_ff && nd_ff == v_d && nc_ff < v_c;
         vwdata = {1'b1, 1'b1, v_d, nc_ff, tail_ff};
      end
   end

   assign vwr = cmd.init_vtx || (cmd.relax_wr && upd_in);

   spct_ram #(.Width(VtxW), .Depth(MaxVertices)) u_vtx (
      .clock(clock), .wr_en(vwr), .addr(vaddr), .wr_data(vwdata), .rd_data(vrdata)
   );

   // Edge fields are held once the edge read returns.
   always_ff @(posedge clock) begin
      if (cmd.vtx_rd) begin
         tail_ff <= e_tail;
         head_ff <= e_head;
         e_dw_ff <= e_dw;
         e_cw_ff <= e_cw;
      end
   end

   // Candidate sums and the skip flag from the tail entry.
   always_ff @(posedge clock) begin
      if (cmd.head_rd) begin
         nd_ff <= spct_pkg::sat_add(v_d, e_dw_ff);
         nc_ff <= spct_pkg::sat_add(v_c, e_cw_ff);
         go_ff <= v_reach && {1'b0, tail_ff} < vcount && {1'b0, head_ff} < vcount;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit;
      end
      if (cmd.emit_rd) begin
         emit_v_ff <= vtx_idx;
      end
      if (cmd.emit) begin
         rsp_vertex          <= emit_v_ff;
         rsp_reachable       <= v_reach;
         rsp_path_distance   <= v_reach ? v_d : spct_pkg::S32Max;
         rsp_path_cost       <= v_reach ? v_c : spct_pkg::S32Max;
         rsp_has_predecessor <= v_pv;
         rsp_predecessor     <= v_pv ? v_p : '0;
         rsp_last            <= ({1'b0, emit_v_ff} + 1'b1) == vcount;
      end
   end
endmodule

FILE: rtl/spct_ctrl.sv
// Sequencer for loads, clears and relaxation runs.
module spct_ctrl #(
   parameter int MaxVertices = spct_pkg::MaxVertices,
   parameter int MaxEdges    = spct_pkg::MaxEdges,
   localparam int VW = $clog2(MaxVertices),
   localparam int EW = $clog2(MaxEdges)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        operation,
   input  logic [VW:0]       vcount,
   input  logic [EW:0]       edge_total,
   output logic              busy,
   output spct_pkg::cmd_type cmd,
   output logic [EW-1:0]     edge_idx,
   output logic [VW-1:0]     vtx_idx
);
   spct_pkg::state_type state_ff, state_in;
   logic [EW:0]  eidx_ff, eidx_in;
   logic [VW:0]  vidx_ff, vidx_in;
   logic [VW:0]  pass_ff, pass_in;
   logic         accept;

   assign accept   = start && !busy;
   assign busy     = state_ff != spct_pkg::ST_IDLE;
   assign edge_idx = eidx_ff[EW-1:0];
   assign vtx_idx  = vidx_ff[VW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spct_pkg::ST_IDLE;
         eidx_ff  <= '0;
         vidx_ff  <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         eidx_ff  <= eidx_in;
         vidx_ff  <= vidx_in;
         pass_ff  <= pass_in;
      end
   end

   // Next state and commands. Per edge: READ, CALC, HEAD, WRITE.
   always_comb begin
      state_in = state_ff;
      eidx_in  = eidx_ff;
      vidx_in  = vidx_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      case (state_ff)
         spct_pkg::ST_IDLE: begin
            if (accept) begin
               case (operation)
                  spct_pkg::OpAppend: cmd.append = 1'b1;
                  spct_pkg::OpClear:  cmd.clear  = 1'b1;
                  spct_pkg::OpRun: begin
                     state_in = spct_pkg::ST_INIT;
                     vidx_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         spct_pkg::ST_INIT: begin
            cmd.init_vtx = 1'b1;
            vidx_in = vidx_ff + 1'b1;
            if (vidx_ff == (VW + 1)'(MaxVertices - 1)) begin
               pass_in = (VW + 1)'(1);
               eidx_in = '0;
               vidx_in = '0;
               if (pass_in >= vcount || edge_total == '0) begin
                  state_in = spct_pkg::ST_EMIT_RD;
               end else begin
                  state_in = spct_pkg::ST_READ;
               end
            end
         end
         spct_pkg::ST_READ: begin
            cmd.edge_rd = 1'b1;
            state_in = spct_pkg::ST_CALC;
         end
         spct_pkg::ST_CALC: begin
            cmd.vtx_rd = 1'b1;
            state_in = spct_pkg::ST_HEAD;
         end
         spct_pkg::ST_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in = spct_pkg::ST_WRITE;
         end
         spct_pkg::ST_WRITE: begin
            // Head entry is on the read port; decide and write back.
            cmd.relax_wr = 1'b1;
            state_in = spct_pkg::ST_READ;
            eidx_in = eidx_ff + 1'b1;
            if (eidx_ff + 1'b1 >= edge_total) begin
               eidx_in = '0;
               pass_in = pass_ff + 1'b1;
               if (pass_ff + 1'b1 >= vcount) begin
                  state_in = spct_pkg::ST_EMIT_RD;
               end
            end
         end
         spct_pkg::ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in = spct_pkg::ST_EMIT;
         end
         spct_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            vidx_in = vidx_ff + 1'b1;
            state_in = spct_pkg::ST_EMIT_RD;
            if (vidx_ff + 1'b1 >= vcount) begin
               state_in = spct_pkg::ST_IDLE;
            end
         end
         default: state_in = spct_pkg::ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.append, cmd.clear, cmd.init_vtx, cmd.edge_rd, cmd.vtx_rd,
                cmd.head_rd, cmd.relax_wr, cmd.emit_rd, cmd.emit}))
      else $error("controller issued two commands at once");
   a_emit_follows_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> $past(cmd.emit_rd))
      else $error("emit without a preceding table read");
   a_write_follows_head: assert property (@(posedge clock) disable iff (reset)
      cmd.relax_wr |-> $past(cmd.head_rd))
      else $error("relaxation write without a head read");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.append || cmd.clear) |-> !busy)
      else $error("edge list changed during a run");
`endif
endmodule

FILE: rtl/shortest_path_with_cost_tiebreak_unit.sv
// Top level of the shortest path unit with cost tie break.
//
// Append and clear beats never raise busy. A run beat raises busy while it
// rebuilds all 64 vertex table entries, then steps every stored edge through
// READ, CALC, HEAD and WRITE on each of (vertex_count - 1) passes (none when
// the list is empty), as the single-port vertex table is read twice per edge
// and may be written once after the edge read, then emits the results.
// Results appear one per strobe on rsp_valid and cannot be stalled; busy
// falls in the cycle that shows the last result, so the next beat can be
// accepted there.
module shortest_path_with_cost_tiebreak_unit #(
   parameter int MaxEdges    = spct_pkg::MaxEdges
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [5:0]         req_from_vertex,
   input  logic [5:0]         req_to_vertex,
   input  logic signed [15:0] req_distance_weight,
   input  logic signed [15:0] req_cost_weight,
   output logic               rsp_valid,
   output logic [5:0]         rsp_vertex,
   output logic               rsp_reachable,
   output logic signed [31:0] rsp_path_distance,
   output logic signed [31:0] rsp_path_cost,
   output logic               rsp_has_predecessor,
   output logic [5:0]         rsp_predecessor,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [6:0]         csr_data
);
   localparam int VW = $clog2(spct_pkg::MaxVertices);
   localparam int EW = $clog2(MaxEdges);

   logic [6:0] vcount_ff;
   logic [5:0] start_ff;
   logic [6:0] vcount_eff;
   spct_pkg::cmd_type cmd;
   logic [EW:0]   edge_total;
   logic [EW-1:0] edge_idx;
   logic [VW-1:0] vtx_idx;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 7'd64;
         start_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            spct_pkg::CsrVertexCount: vcount_ff <= csr_data;
            spct_pkg::CsrStartVertex: start_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Vertex count clamped to 1..64.
   always_comb begin
      vcount_eff = vcount_ff;
      if (vcount_ff == '0) vcount_eff = 7'd1;
      if (vcount_ff > 7'd64) vcount_eff = 7'd64;
   end

   spct_ctrl #(.MaxVertices(spct_pkg::MaxVertices), .MaxEdges(MaxEdges)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .operation(req_operation),
      .vcount(vcount_eff), .edge_total(edge_total), .busy(busy), .cmd(cmd),
      .edge_idx(edge_idx), .vtx_idx(vtx_idx)
   );

   spct_datapath #(.MaxVertices(spct_pkg::MaxVertices), .MaxEdges(MaxEdges)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .edge_idx(edge_idx),
      .vtx_idx(vtx_idx), .from_vertex(req_from_vertex), .to_vertex(req_to_vertex),
      .distance_weight(req_distance_weight), .cost_weight(req_cost_weight),
      .vcount(vcount_eff), .start_vertex(start_ff), .edge_total(edge_total),
      .rsp_valid(rsp_valid), .rsp_vertex(rsp_vertex), .rsp_reachable(rsp_reachable),
      .rsp_path_distance(rsp_path_distance), .rsp_path_cost(rsp_path_cost),
      .rsp_has_predecessor(rsp_has_predecessor), .rsp_predecessor(rsp_predecessor),
      .rsp_last(rsp_last)
   );
endmodule
